// ----- rtl/jst_pkg.sv -----
`timescale 1ns / 1ps
// shared types, codes and character helpers of the json stream tokenizer
package jst_pkg;

    localparam int POSITION_BITS_DEFAULT = 32;
    localparam int FIFO_DEPTH = 4;

    // one-hot lexer modes
    typedef enum logic [19:0] {
        MODE_IDLE   = 20'h00001,
        MODE_TRUE   = 20'h00002,
        MODE_FALSE  = 20'h00004,
        MODE_NULL   = 20'h00008,
        MODE_STR    = 20'h00010,
        MODE_ESC    = 20'h00020,
        MODE_HEX    = 20'h00040,
        MODE_UTF    = 20'h00080,
        MODE_NMINUS = 20'h00100,
        MODE_NZERO  = 20'h00200,
        MODE_NINT   = 20'h00400,
        MODE_NPOINT = 20'h00800,
        MODE_NFRAC  = 20'h01000,
        MODE_NEXP   = 20'h02000,
        MODE_NESIGN = 20'h04000,
        MODE_NEXPD  = 20'h08000,
        MODE_CSLASH = 20'h10000,
        MODE_CLINE  = 20'h20000,
        MODE_CBLOCK = 20'h40000,
        MODE_CSTAR  = 20'h80000
    } mode_t;

    // token kinds
    localparam logic [3:0] K_LBRACE  = 4'd0;
    localparam logic [3:0] K_RBRACE  = 4'd1;
    localparam logic [3:0] K_LBRACK  = 4'd2;
    localparam logic [3:0] K_RBRACK  = 4'd3;
    localparam logic [3:0] K_COMMA   = 4'd4;
    localparam logic [3:0] K_COLON   = 4'd5;
    localparam logic [3:0] K_BOOL    = 4'd6;
    localparam logic [3:0] K_NULL    = 4'd7;
    localparam logic [3:0] K_STRING  = 4'd8;
    localparam logic [3:0] K_ESTRING = 4'd9;
    localparam logic [3:0] K_INT     = 4'd10;
    localparam logic [3:0] K_DOUBLE  = 4'd11;
    localparam logic [3:0] K_ERROR   = 4'd12;
    localparam logic [3:0] K_END     = 4'd13;
    localparam logic [3:0] K_TRUNC   = 4'd14;

    // error codes
    localparam logic [3:0] E_NONE       = 4'd0;
    localparam logic [3:0] E_UTF8       = 4'd1;
    localparam logic [3:0] E_ESCAPE     = 4'd2;
    localparam logic [3:0] E_STR_CHAR   = 4'd3;
    localparam logic [3:0] E_HEX        = 4'd4;
    localparam logic [3:0] E_CHAR       = 4'd5;
    localparam logic [3:0] E_LITERAL    = 4'd6;
    localparam logic [3:0] E_EXP_DIGIT  = 4'd7;
    localparam logic [3:0] E_FRAC_DIGIT = 4'd8;
    localparam logic [3:0] E_SIGN_DIGIT = 4'd9;
    localparam logic [3:0] E_COMMENT    = 4'd10;

    // register indexes
    localparam logic REG_COMMENTS = 1'b0;
    localparam logic REG_UTF8     = 1'b1;

    // utf-8 lead patterns
    localparam logic [2:0] UTF_LEAD2 = 3'h6;
    localparam logic [3:0] UTF_LEAD3 = 4'he;
    localparam logic [4:0] UTF_LEAD4 = 5'h1e;
    localparam logic [1:0] UTF_CONT  = 2'h2;

    // characters
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_POINT  = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0b;
    localparam logic [7:0] CH_FF     = 8'h0c;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;

    typedef struct packed {
        logic comments_enabled;
        logic check_utf8;
    } cfg_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [3:0]  error_code;
        logic [31:0] token_start;
        logic [31:0] token_length;
        logic        last_result;
    } tok_t;

    // results of one beat
    typedef struct packed {
        logic [1:0] count;
        tok_t       r0;
        tok_t       r1;
    } lex_res_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return is_digit(b) || ((b >= 8'h61) && (b <= 8'h66)) ||
               ((b >= 8'h41) && (b <= 8'h46));
    endfunction

    function automatic logic is_esc(input logic [7:0] b);
        return (b == CH_QUOTE) || (b == CH_BSLASH) || (b == CH_SLASH) ||
               (b == 8'h62) || (b == 8'h66) || (b == 8'h6e) ||
               (b == 8'h72) || (b == 8'h74);
    endfunction

    // tails of true, false, null after the first letter
    function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [1:0] i);
        logic [7:0] c;
        c = 8'h00;
        case (w)
            2'd0:    c = (i == 2'd0) ? 8'h72 : (i == 2'd1) ? 8'h75 : 8'h65;
            2'd1:    c = (i == 2'd0) ? 8'h61 : (i == 2'd1) ? 8'h6c :
                         (i == 2'd2) ? 8'h73 : 8'h65;
            default: c = (i == 2'd0) ? 8'h75 : 8'h6c;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] lit_len(input logic [1:0] w);
        return (w == 2'd1) ? 3'd4 : 3'd3;
    endfunction

endpackage

// ----- rtl/jst_in_if.sv -----
`timescale 1ns / 1ps
// input channel: text bytes and end marker
interface jst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_marker;

    modport source (output valid, output text_byte, output end_marker, input ready);
    modport sink (input valid, input text_byte, input end_marker, output ready);
endinterface

// ----- rtl/jst_out_if.sv -----
`timescale 1ns / 1ps
// output channel: token records
interface jst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [3:0]  error_code;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_result;

    modport source (output valid, output token_kind, output error_code, output token_start,
                    output token_length, output last_result, input ready);
    modport sink (input valid, input token_kind, input error_code, input token_start,
                  input token_length, input last_result, output ready);
endinterface

// ----- rtl/jst_lexer.sv -----
`timescale 1ns / 1ps
// lexer state and per-beat token logic
module jst_lexer #(
    parameter int POSITION_BITS = jst_pkg::POSITION_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       text_byte,
    input  logic             end_marker,
    input  jst_pkg::cfg_t    cfg,
    output jst_pkg::lex_res_t res
);
    import jst_pkg::*;

    localparam int PW = POSITION_BITS;

    mode_t          mode_reg, mode_next;
    logic [1:0]     lit_reg, lit_next;
    logic [2:0]     left_reg, left_next;
    logic           esc_reg, esc_next;
    logic           dbl_reg, dbl_next;
    logic [PW-1:0]  bp_reg, bp_next;
    logic [PW-1:0]  sp_reg, sp_next;
    logic           err_reg, err_next;

    tok_t           slot [2];
    logic [1:0]     n;
    logic           do_idle;
    logic [1:0]     w;
    logic [2:0]     llen;
    logic [PW-1:0]  bp_inc;

    function automatic tok_t mk(input logic [3:0] k, input logic [3:0] e,
                                input logic [64:0] s, input logic [64:0] l);
        tok_t t;
        t.token_kind   = k;
        t.error_code   = e;
        t.token_start  = (s > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
        t.token_length = (l > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : l[31:0];
        t.last_result  = 1'b0;
        return t;
    endfunction

    assign bp_inc = (bp_reg != {PW{1'b1}}) ? bp_reg + 1'b1 : bp_reg;
    assign w = (mode_reg == MODE_TRUE) ? 2'd0 : (mode_reg == MODE_FALSE) ? 2'd1 : 2'd2;
    assign llen = lit_len(w);

    always_comb
    begin
        mode_next = mode_reg;
        lit_next  = lit_reg;
        left_next = left_reg;
        esc_next  = esc_reg;
        dbl_next  = dbl_reg;
        bp_next   = bp_reg;
        sp_next   = sp_reg;
        err_next  = err_reg;
        slot[0]   = '0;
        slot[1]   = '0;
        n         = 2'd0;
        do_idle   = 1'b0;

        if (fire && end_marker)
        begin
            if (err_reg)
            begin
                slot[n[0]] = mk(K_TRUNC, E_NONE, 65'(bp_reg), '0);
                n = n + 2'd1;
            end
            else
            begin
                unique case (mode_reg)
                    MODE_IDLE:
                    begin
                        slot[n[0]] = mk(K_END, E_NONE, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                    MODE_NZERO, MODE_NINT, MODE_NFRAC, MODE_NEXPD:
                    begin
                        slot[n[0]] = mk(dbl_reg ? K_DOUBLE : K_INT, E_NONE, 65'(sp_reg),
                                        65'(bp_reg - sp_reg));
                        n = n + 2'd1;
                        slot[n[0]] = mk(K_END, E_NONE, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                    MODE_NMINUS:
                    begin
                        slot[n[0]] = mk(K_ERROR, E_SIGN_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                    MODE_NPOINT:
                    begin
                        slot[n[0]] = mk(K_ERROR, E_FRAC_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                    MODE_NEXP, MODE_NESIGN:
                    begin
                        slot[n[0]] = mk(K_ERROR, E_EXP_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                    default:
                    begin
                        slot[n[0]] = mk(K_TRUNC, E_NONE, 65'(bp_reg), '0);
                        n = n + 2'd1;
                    end
                endcase
            end
            mode_next = MODE_IDLE;
            lit_next  = '0;
            left_next = '0;
            esc_next  = 1'b0;
            dbl_next  = 1'b0;
            bp_next   = '0;
            sp_next   = '0;
            err_next  = 1'b0;
        end
        else if (fire && !err_reg)
        begin
            bp_next = bp_inc;
            unique case (mode_reg)
                MODE_TRUE, MODE_FALSE, MODE_NULL:
                begin
                    if (({1'b0, lit_reg} >= llen) || (text_byte != lit_char(w, lit_reg)))
                    begin
                        slot[n[0]] = mk(K_ERROR, E_LITERAL, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else if ((3'(lit_reg) + 3'd1) == llen)
                    begin
                        slot[n[0]] = mk((w == 2'd2) ? K_NULL : K_BOOL, E_NONE, 65'(sp_reg),
                                        65'(bp_reg) - 65'(sp_reg) + 65'd1);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        lit_next = '0;
                    end
                    else
                    begin
                        lit_next = lit_reg + 2'd1;
                    end
                end
                MODE_STR:
                begin
                    if (text_byte == CH_QUOTE)
                    begin
                        slot[n[0]] = mk(esc_reg ? K_ESTRING : K_STRING, E_NONE, 65'(sp_reg),
                                        (bp_reg >= sp_reg) ? 65'(bp_reg - sp_reg) : '0);
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte == CH_BSLASH)
                    begin
                        esc_next = 1'b1;
                        mode_next = MODE_ESC;
                    end
                    else if (text_byte < CH_SPACE)
                    begin
                        slot[n[0]] = mk(K_ERROR, E_STR_CHAR, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else if (text_byte[7] && cfg.check_utf8)
                    begin
                        if (text_byte[7:5] == UTF_LEAD2)
                        begin
                            left_next = 3'd1;
                            mode_next = MODE_UTF;
                        end
                        else if (text_byte[7:4] == UTF_LEAD3)
                        begin
                            left_next = 3'd2;
                            mode_next = MODE_UTF;
                        end
                        else if (text_byte[7:3] == UTF_LEAD4)
                        begin
                            left_next = 3'd3;
                            mode_next = MODE_UTF;
                        end
                        else
                        begin
                            slot[n[0]] = mk(K_ERROR, E_UTF8, 65'(bp_reg), '0);
                            n = n + 2'd1;
                            err_next = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                end
                MODE_ESC:
                begin
                    if (text_byte == CH_U)
                    begin
                        mode_next = MODE_HEX;
                        left_next = 3'd4;
                    end
                    else if (is_esc(text_byte))
                    begin
                        mode_next = MODE_STR;
                    end
                    else
                    begin
                        slot[n[0]] = mk(K_ERROR, E_ESCAPE, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HEX, MODE_UTF:
                begin
                    if ((mode_reg == MODE_HEX) ? !is_hex(text_byte)
                                               : (text_byte[7:6] != UTF_CONT))
                    begin
                        slot[n[0]] = mk(K_ERROR, (mode_reg == MODE_HEX) ? E_HEX : E_UTF8,
                                        65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                    else if (left_reg <= 3'd1)
                    begin
                        left_next = '0;
                        mode_next = MODE_STR;
                    end
                    else
                    begin
                        left_next = left_reg - 3'd1;
                    end
                end
                MODE_NMINUS:
                begin
                    if (text_byte == CH_ZERO)
                        mode_next = MODE_NZERO;
                    else if (is_digit(text_byte))
                        mode_next = MODE_NINT;
                    else
                    begin
                        slot[n[0]] = mk(K_ERROR, E_SIGN_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NZERO, MODE_NINT, MODE_NFRAC, MODE_NEXPD:
                begin
                    if (is_digit(text_byte) && (mode_reg != MODE_NZERO))
                    begin
                        mode_next = mode_reg;
                    end
                    else if ((text_byte == CH_POINT) && (mode_reg != MODE_NFRAC)
                             && (mode_reg != MODE_NEXPD))
                    begin
                        mode_next = MODE_NPOINT;
                        dbl_next = 1'b1;
                    end
                    else if (((text_byte == CH_E_LO) || (text_byte == CH_E_UP))
                             && (mode_reg != MODE_NEXPD))
                    begin
                        mode_next = MODE_NEXP;
                        dbl_next = 1'b1;
                    end
                    else
                    begin
                        slot[n[0]] = mk(dbl_reg ? K_DOUBLE : K_INT, E_NONE, 65'(sp_reg),
                                        65'(bp_reg - sp_reg));
                        n = n + 2'd1;
                        mode_next = MODE_IDLE;
                        do_idle = 1'b1;
                    end
                end
                MODE_NPOINT:
                begin
                    if (is_digit(text_byte))
                        mode_next = MODE_NFRAC;
                    else
                    begin
                        slot[n[0]] = mk(K_ERROR, E_FRAC_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_NEXP, MODE_NESIGN:
                begin
                    if ((mode_reg == MODE_NEXP) &&
                        ((text_byte == CH_PLUS) || (text_byte == CH_MINUS)))
                        mode_next = MODE_NESIGN;
                    else if (is_digit(text_byte))
                        mode_next = MODE_NEXPD;
                    else
                    begin
                        slot[n[0]] = mk(K_ERROR, E_EXP_DIGIT, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CSLASH:
                begin
                    if (text_byte == CH_SLASH)
                        mode_next = MODE_CLINE;
                    else if (text_byte == CH_STAR)
                        mode_next = MODE_CBLOCK;
                    else
                    begin
                        slot[n[0]] = mk(K_ERROR, E_CHAR, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_CLINE:
                begin
                    if (text_byte == CH_LF)
                        mode_next = MODE_IDLE;
                end
                MODE_CBLOCK:
                begin
                    if (text_byte == CH_STAR)
                        mode_next = MODE_CSTAR;
                end
                MODE_CSTAR:
                begin
                    if (text_byte == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else if (text_byte != CH_STAR)
                        mode_next = MODE_CBLOCK;
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    do_idle = 1'b1;
                end
            endcase

            // byte lexed between tokens, also the byte that ends a number
            if (do_idle)
            begin
                sp_next = bp_reg;
                case (text_byte) inside
                    CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_COLON:
                    begin
                        slot[n[0]] = mk((text_byte == CH_LBRACE) ? K_LBRACE :
                                        (text_byte == CH_RBRACE) ? K_RBRACE :
                                        (text_byte == CH_LBRACK) ? K_LBRACK :
                                        (text_byte == CH_RBRACK) ? K_RBRACK :
                                        (text_byte == CH_COMMA)  ? K_COMMA : K_COLON,
                                        E_NONE, 65'(bp_reg), 65'd1);
                        n = n + 2'd1;
                    end
                    CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    CH_T:
                    begin
                        mode_next = MODE_TRUE;
                        lit_next = '0;
                    end
                    CH_F:
                    begin
                        mode_next = MODE_FALSE;
                        lit_next = '0;
                    end
                    CH_N:
                    begin
                        mode_next = MODE_NULL;
                        lit_next = '0;
                    end
                    CH_QUOTE:
                    begin
                        mode_next = MODE_STR;
                        esc_next = 1'b0;
                        sp_next = bp_inc;
                    end
                    CH_MINUS:
                    begin
                        mode_next = MODE_NMINUS;
                        dbl_next = 1'b0;
                    end
                    CH_ZERO:
                    begin
                        mode_next = MODE_NZERO;
                        dbl_next = 1'b0;
                    end
                    [CH_ONE:CH_NINE]:
                    begin
                        mode_next = MODE_NINT;
                        dbl_next = 1'b0;
                    end
                    CH_SLASH:
                    begin
                        if (cfg.comments_enabled)
                            mode_next = MODE_CSLASH;
                        else
                        begin
                            slot[n[0]] = mk(K_ERROR, E_COMMENT, 65'(bp_reg), '0);
                            n = n + 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        slot[n[0]] = mk(K_ERROR, E_CHAR, 65'(bp_reg), '0);
                        n = n + 2'd1;
                        err_next = 1'b1;
                    end
                endcase
            end
        end

        if (n == 2'd1)
            slot[0].last_result = 1'b1;
        if (n == 2'd2)
            slot[1].last_result = 1'b1;
    end

    assign res.count = n;
    assign res.r0 = slot[0];
    assign res.r1 = slot[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            lit_reg  <= '0;
            left_reg <= '0;
            esc_reg  <= 1'b0;
            dbl_reg  <= 1'b0;
            bp_reg   <= '0;
            sp_reg   <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            lit_reg  <= lit_next;
            left_reg <= left_next;
            esc_reg  <= esc_next;
            dbl_reg  <= dbl_next;
            bp_reg   <= bp_next;
            sp_reg   <= sp_next;
            err_reg  <= err_next;
        end
    end

    a_held_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !end_marker && err_reg) |-> (n == 2'd0))
        else $error("result while error held");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && end_marker) |=> ((bp_reg == '0) && !err_reg && (mode_reg == MODE_IDLE)))
        else $error("end marker did not clear state");
    a_pair_number: assert property (@(posedge clk) disable iff (!rst_n)
        (n == 2'd2) |-> ((slot[0].token_kind == K_INT) || (slot[0].token_kind == K_DOUBLE)))
        else $error("two results not led by a number");
endmodule

// ----- rtl/jst_out_fifo.sv -----
`timescale 1ns / 1ps
// small result queue, takes up to two records per beat
module jst_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  jst_pkg::lex_res_t res,
    output logic              room,
    jst_out_if.source         token_out
);
    import jst_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    tok_t            mem_reg [FIFO_DEPTH];
    logic [AW-1:0]   wp_reg, wp_next;
    logic [AW-1:0]   rp_reg, rp_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            pop;
    tok_t            head;

    assign room = (cnt_reg <= (AW + 1)'(FIFO_DEPTH - 2));
    assign pop  = token_out.valid && token_out.ready;
    assign head = mem_reg[rp_reg];

    assign token_out.valid        = (cnt_reg != '0);
    assign token_out.token_kind   = head.token_kind;
    assign token_out.error_code   = head.error_code;
    assign token_out.token_start  = head.token_start;
    assign token_out.token_length = head.token_length;
    assign token_out.last_result  = head.last_result;

    always_comb
    begin
        wp_next  = wp_reg + AW'(res.count);
        rp_next  = pop ? rp_reg + 1'b1 : rp_reg;
        cnt_next = cnt_reg + (AW + 1)'(res.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (res.count != 2'd0)
            mem_reg[wp_reg] <= res.r0;
        if (res.count == 2'd2)
            mem_reg[wp_reg + 1'b1] <= res.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (res.count != 2'd0) |-> room)
        else $error("push into full queue");
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW + 1)'(FIFO_DEPTH))
        else $error("queue count out of range");
    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (res.count == 2'd0)) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count lost a pop");
endmodule

// ----- rtl/json_stream_tokenizer.sv -----
`timescale 1ns / 1ps
// top level of the json stream tokenizer
//
// byte_in carries one byte of json text per beat, or an end marker beat that
// closes the input. token_out carries token records: kind, error code,
// start position, length and a flag on the last record of each input beat.
// an input beat gives zero, one or two records; two come when a byte ends a
// number and then starts or is a token of its own, or when the end marker
// closes a number. the lexer decodes each accepted beat combinationally from
// its mode registers; records are registered into a four-entry queue that
// drives token_out.
// throughput is one byte per cycle; byte_in.ready drops only while the queue
// holds more than two records, which happens when token_out is stalled or
// after beats that gave two records.
// the apb port holds two registers: comments_enabled at 0x0 and check_utf8
// at 0x4; write them only while no beat is in flight. reset (rst_n low)
// clears the lexer, empties the queue and restores the register defaults.
module json_stream_tokenizer #(
    parameter int POSITION_BITS = jst_pkg::POSITION_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    jst_in_if.sink      byte_in,
    jst_out_if.source   token_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import jst_pkg::*;

    cfg_t      cfg_reg;
    lex_res_t  res;
    logic      room;
    logic      fire;

    // config registers, written on the access phase
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comments_enabled <= 1'b0;
            cfg_reg.check_utf8       <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_COMMENTS: cfg_reg.comments_enabled <= pwdata[0];
                REG_UTF8:     cfg_reg.check_utf8       <= pwdata[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_COMMENTS: prdata = {31'b0, cfg_reg.comments_enabled};
            REG_UTF8:     prdata = {31'b0, cfg_reg.check_utf8};
            default:      prdata = '0;
        endcase
    end

    // accept a beat whenever the queue can take two more records
    assign byte_in.ready = room;
    assign fire = byte_in.valid && room;

    jst_lexer #(
        .POSITION_BITS (POSITION_BITS)
    ) u_lexer (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .text_byte  (byte_in.text_byte),
        .end_marker (byte_in.end_marker),
        .cfg        (cfg_reg),
        .res        (res)
    );

    jst_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .room      (room),
        .token_out (token_out)
    );
endmodule
